>>> src/pdsg_pkg.sv
// Shared types, widths, codes and reset values of the shake generator.
package pdsg_pkg;

    // Field widths
    localparam int ACTION_W   = 2;
    localparam int DUR_W      = 15;
    localparam int AMP_W      = 13;
    localparam int STEP_W     = 16;
    localparam int TIME_W     = 16;
    localparam int OFF_W      = 14;
    localparam int SINE_W     = 16;
    localparam int MAG_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Sine full scale and the divide datapath widths
    localparam int SINE_FULL  = 32767;
    localparam int SCALE_W    = AMP_W + DUR_W;
    localparam int NUM_W      = SCALE_W + MAG_W;
    localparam int DEN_W      = DUR_W + MAG_W;
    localparam int QUO_W      = AMP_W;

    // Configuration reset values
    localparam logic [DUR_W-1:0]  SHAKE_DUR_RST = 15'd5000;
    localparam logic [DUR_W-1:0]  REST_DUR_RST  = 15'd10000;
    localparam logic [AMP_W-1:0]  AMP_V_RST     = 13'd1024;
    localparam logic [AMP_W-1:0]  AMP_H_RST     = 13'd512;
    localparam logic [STEP_W-1:0] STEP_V_RST    = 16'd626;
    localparam logic [STEP_W-1:0] STEP_H_RST    = 16'd469;

    // Item actions; the unused code behaves as stop
    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2
    } action_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHAKE_DUR = 3'd0,
        REG_REST_DUR  = 3'd1,
        REG_AMP_V     = 3'd2,
        REG_AMP_H     = 3'd3,
        REG_STEP_V    = 3'd4,
        REG_STEP_H    = 3'd5
    } reg_index_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;     // take the input transaction, update timers
        logic phase_mul;  // sine phase, decay numerator, divisor
        logic scale_mul;  // amplitude times remaining time
        logic div_start;  // full product into the divider
        logic store;      // signed quotient into the axis offset
        logic axis;       // 0 horizontal, 1 vertical
        logic load_out;   // move offsets into the output register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic calc;       // this tick computes offsets
        logic div_busy;   // divider still iterating
    } dp_status_t;

endpackage

>>> src/pdsg_item_if.sv
// Input channel: action and elapsed milliseconds with valid/ready.
interface pdsg_item_if
    import pdsg_pkg::*;
#(
    parameter int DT_BITS = 10
);
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [DT_BITS-1:0]  dt_ms;

    modport source (output valid, action, dt_ms, input ready);
    modport sink   (input valid, action, dt_ms, output ready);
endinterface

>>> src/pdsg_result_if.sv
// Result channel: per-axis offsets and shake flag with valid/ready.
interface pdsg_result_if
    import pdsg_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [OFF_W-1:0] offset_horizontal;
    logic signed [OFF_W-1:0] offset_vertical;
    logic                    in_shake;

    modport source (output valid, offset_horizontal, offset_vertical, in_shake, input ready);
    modport sink   (input valid, offset_horizontal, offset_vertical, in_shake, output ready);
endinterface

>>> src/pdsg_cfg_if.sv
// Configuration write channel: register index and data with valid/ready.
interface pdsg_cfg_if
    import pdsg_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/pdsg_sine_rom.sv
// Sine ROM, contents built at elaboration, registered read data.
module pdsg_sine_rom
    import pdsg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024
)
(
    input  logic                               clk,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr,
    output logic signed [SINE_W-1:0]           q
);

    typedef longint unsigned u64_t;
    typedef logic signed [SINE_W-1:0] rom_t [SINE_TABLE_DEPTH];

    localparam u64_t ONE_Q32     = 64'd4294967296;
    localparam u64_t HALF_PI_Q32 = 64'd6746518852;
    localparam u64_t DEPTH_U64   = u64_t'(SINE_TABLE_DEPTH);

    // (a*b) >> 32 in Q32 without overflow
    function automatic u64_t mul_q32(input u64_t a, input u64_t b);
        return ((a >> 16) * b + (((a & 64'hFFFF) * b) >> 16)) >> 16;
    endfunction

    // Floor quotient by long division; divisors here stay small
    function automatic u64_t udiv(input u64_t a, input u64_t d);
        u64_t quo_v;
        u64_t rem_v;
        quo_v = '0;
        rem_v = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem_v = (rem_v << 1) | u64_t'(a[b]);
            if (rem_v >= d)
            begin
                rem_v    = rem_v - d;
                quo_v[b] = 1'b1;
            end
        end
        return quo_v;
    endfunction

    // Taylor series of sin (odd) or cos (even) over a quarter turn
    function automatic u64_t taylor_q32(input u64_t x, input logic odd);
        u64_t   x2;
        u64_t   term;
        u64_t   n;
        longint sum;
        x2   = mul_q32(x, x);
        term = odd ? x : ONE_Q32;
        sum  = longint'(term);
        n    = odd ? 64'd1 : 64'd0;
        for (int k = 1; k <= 9; k++)
        begin
            term = udiv(mul_q32(term, x2), (n + 64'd1) * (n + 64'd2));
            n    = n + 64'd2;
            if (k[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(ONE_Q32))
            sum = longint'(ONE_Q32);
        return u64_t'(sum);
    endfunction

    // Fold each entry onto the first quarter and round to full scale
    function automatic rom_t build_rom();
        rom_t rom;
        u64_t quarter;
        u64_t rem_q;
        u64_t ang;
        u64_t v;
        u64_t m;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
        begin
            quarter = udiv(u64_t'(i) << 2, DEPTH_U64);
            rem_q   = (u64_t'(i) << 2) - quarter * DEPTH_U64;
            ang     = udiv(HALF_PI_Q32 * rem_q, DEPTH_U64);
            v       = taylor_q32(ang, quarter[0] == 1'b0);
            m       = (v * u64_t'(SINE_FULL) + (ONE_Q32 >> 1)) >> 32;
            if (m > u64_t'(SINE_FULL))
                m = u64_t'(SINE_FULL);
            rom[i] = quarter[1] ? -SINE_W'(m) : SINE_W'(m);
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic signed [SINE_W-1:0] rd_reg;

    // Registered lookup
    always_ff @(posedge clk)
    begin
        rd_reg <= SINE_ROM[addr];
    end

    assign q = rd_reg;

endmodule

>>> src/pdsg_divider.sv
// Restoring divider, one quotient bit per cycle, quotient known below 2^QUO_W.
module pdsg_divider
    import pdsg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [QUO_W-1:0] quo
);

    localparam int DSH_W = DEN_W + QUO_W - 1;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [DSH_W-1:0] dsh_reg;
    logic [QUO_W-1:0] quo_reg;

    logic             fits;
    logic [NUM_W-1:0] rem_sub;

    // Trial subtract of the shifted divisor
    assign fits    = rem_reg >= NUM_W'(dsh_reg);
    assign rem_sub = rem_reg - NUM_W'(dsh_reg);

    // Iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(QUO_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    // Remainder, divisor and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= {den, {(QUO_W-1){1'b0}}};
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_reg <= rem_sub;
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while iterating");

    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with no steps left");

endmodule

>>> src/pdsg_datapath.sv
// Datapath: configuration, timers, sine lookup, products, divide, offsets.
module pdsg_datapath
    import pdsg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int DT_BITS          = 10
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [ACTION_W-1:0]     item_action,
    input  logic [DT_BITS-1:0]      item_dt,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  dp_cmd_t                 cmd,
    output dp_status_t              status,
    output logic signed [OFF_W-1:0] out_h,
    output logic signed [OFF_W-1:0] out_v,
    output logic                    out_shake
);

    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);
    localparam int IDX_W  = TIME_W + ADDR_W;

    // Configuration registers
    logic [DUR_W-1:0]  shake_dur_reg;
    logic [DUR_W-1:0]  rest_dur_reg;
    logic [AMP_W-1:0]  amp_v_reg;
    logic [AMP_W-1:0]  amp_h_reg;
    logic [STEP_W-1:0] step_v_reg;
    logic [STEP_W-1:0] step_h_reg;

    // Timer state
    logic              running_reg, running_next;
    logic              shake_reg, shake_next;
    logic [TIME_W-1:0] pt_reg, pt_next;
    logic [TIME_W-1:0] el_reg, el_next;
    logic              calc_reg, calc_next;

    // Working registers
    logic [TIME_W-1:0]       phase_reg;
    logic [DUR_W-1:0]        diff_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [SCALE_W-1:0]      scale_reg;
    logic                    neg_reg;
    logic signed [OFF_W-1:0] off_h_reg;
    logic signed [OFF_W-1:0] off_v_reg;
    logic signed [OFF_W-1:0] out_h_reg;
    logic signed [OFF_W-1:0] out_v_reg;
    logic                    out_shake_reg;

    logic [TIME_W:0]          t_sum;
    logic [TIME_W-1:0]        t_sat;
    logic [TIME_W-1:0]        el_sum;
    logic [AMP_W-1:0]         amp_sel;
    logic [STEP_W-1:0]        step_sel;
    logic [2*TIME_W-1:0]      phase_prod;
    logic [IDX_W-1:0]         idx_prod;
    logic signed [SINE_W-1:0] rom_q;
    logic [SINE_W-1:0]        rom_abs;
    logic [NUM_W-1:0]         num_prod;
    logic                     div_busy;
    logic [QUO_W-1:0]         quo;
    logic signed [OFF_W-1:0]  off_signed;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shake_dur_reg <= SHAKE_DUR_RST;
            rest_dur_reg  <= REST_DUR_RST;
            amp_v_reg     <= AMP_V_RST;
            amp_h_reg     <= AMP_H_RST;
            step_v_reg    <= STEP_V_RST;
            step_h_reg    <= STEP_H_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SHAKE_DUR: shake_dur_reg <= cfg_data[DUR_W-1:0];
                REG_REST_DUR:  rest_dur_reg  <= cfg_data[DUR_W-1:0];
                REG_AMP_V:     amp_v_reg     <= cfg_data[AMP_W-1:0];
                REG_AMP_H:     amp_h_reg     <= cfg_data[AMP_W-1:0];
                REG_STEP_V:    step_v_reg    <= cfg_data[STEP_W-1:0];
                REG_STEP_H:    step_h_reg    <= cfg_data[STEP_W-1:0];
                default:       ;
            endcase
        end
    end

    // Advance the phase timer (saturating) and the shake clock (wrapping)
    assign t_sum  = {1'b0, pt_reg} + (TIME_W+1)'(item_dt);
    assign t_sat  = t_sum[TIME_W] ? {TIME_W{1'b1}} : t_sum[TIME_W-1:0];
    assign el_sum = el_reg + TIME_W'(item_dt);

    // Next timer state for an accepted transaction
    always_comb
    begin
        running_next = running_reg;
        shake_next   = shake_reg;
        pt_next      = pt_reg;
        el_next      = el_reg;
        calc_next    = calc_reg;
        if (cmd.accept)
        begin
            calc_next = 1'b0;
            if (item_action != ACT_TICK)
            begin
                running_next = (item_action == ACT_START);
                shake_next   = 1'b0;
                pt_next      = '0;
                el_next      = '0;
            end
            else if (running_reg)
            begin
                if (shake_reg)
                begin
                    el_next = el_sum;
                    if (t_sat >= TIME_W'(shake_dur_reg))
                    begin
                        shake_next = 1'b0;
                        pt_next    = '0;
                    end
                    else
                    begin
                        pt_next   = t_sat;
                        calc_next = 1'b1;
                    end
                end
                else if (t_sat >= TIME_W'(rest_dur_reg))
                begin
                    shake_next = 1'b1;
                    pt_next    = '0;
                    el_next    = '0;
                end
                else
                begin
                    pt_next = t_sat;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            shake_reg   <= 1'b0;
            pt_reg      <= '0;
            el_reg      <= '0;
            calc_reg    <= 1'b0;
        end
        else
        begin
            running_reg <= running_next;
            shake_reg   <= shake_next;
            pt_reg      <= pt_next;
            el_reg      <= el_next;
            calc_reg    <= calc_next;
        end
    end

    // Axis select: 0 horizontal, 1 vertical
    assign amp_sel  = cmd.axis ? amp_v_reg : amp_h_reg;
    assign step_sel = cmd.axis ? step_v_reg : step_h_reg;

    // Products and sign handling
    assign phase_prod = el_reg * step_sel;
    assign rom_abs    = rom_q[SINE_W-1] ? SINE_W'(-rom_q) : SINE_W'(rom_q);
    assign num_prod   = scale_reg * rom_abs[MAG_W-1:0];
    assign off_signed = neg_reg ? -OFF_W'(quo) : OFF_W'(quo);

    // Scale the turn fraction onto the table depth
    assign idx_prod = IDX_W'(phase_reg) * IDX_W'(SINE_TABLE_DEPTH);

    // Sequence the per-axis arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.phase_mul)
        begin
            phase_reg <= phase_prod[TIME_W-1:0];
            diff_reg  <= shake_dur_reg - pt_reg[DUR_W-1:0];
            den_reg   <= DEN_W'(shake_dur_reg) * DEN_W'(SINE_FULL);
        end
        if (cmd.scale_mul)
            scale_reg <= amp_sel * diff_reg;
        if (cmd.div_start)
            neg_reg <= rom_q[SINE_W-1];
        if (cmd.accept)
        begin
            off_h_reg <= '0;
            off_v_reg <= '0;
        end
        else if (cmd.store)
        begin
            if (cmd.axis)
                off_v_reg <= off_signed;
            else
                off_h_reg <= off_signed;
        end
        if (cmd.load_out)
        begin
            out_h_reg     <= off_h_reg;
            out_v_reg     <= off_v_reg;
            out_shake_reg <= shake_reg;
        end
    end

    pdsg_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .clk  (clk),
        .addr (idx_prod[IDX_W-1 -: ADDR_W]),
        .q    (rom_q)
    );

    pdsg_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_prod),
        .den   (den_reg),
        .busy  (div_busy),
        .quo   (quo)
    );

    assign status.calc     = calc_reg;
    assign status.div_busy = div_busy;
    assign out_h           = out_h_reg;
    assign out_v           = out_v_reg;
    assign out_shake       = out_shake_reg;

    a_shake_running: assert property (@(posedge clk) disable iff (!rst_n)
        shake_reg |-> running_reg)
        else $error("shake phase while disabled");

    a_stopped_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (pt_reg == '0 && el_reg == '0))
        else $error("timers not cleared while disabled");

endmodule

>>> src/pdsg_ctrl.sv
// Controller: sequences one transaction through the datapath.
module pdsg_ctrl
    import pdsg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_PHASE,
        S_SCALE,
        S_MUL,
        S_DIV,
        S_STORE,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   axis_reg, axis_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    // Output register is free when empty or being drained
    assign slot_free = !out_valid_reg || out_ready;

    // Commands decoded from the current state
    always_comb
    begin
        cmd           = '0;
        cmd.axis      = axis_reg;
        cmd.accept    = (state_reg == S_IDLE) && in_valid;
        cmd.phase_mul = (state_reg == S_PHASE);
        cmd.scale_mul = (state_reg == S_SCALE);
        cmd.div_start = (state_reg == S_MUL);
        cmd.store     = (state_reg == S_STORE);
        cmd.load_out  = (state_reg == S_FINISH) && slot_free;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                axis_next  = 1'b0;
                state_next = status.calc ? S_PHASE : S_FINISH;
            end
            S_PHASE:  state_next = S_SCALE;
            S_SCALE:  state_next = S_MUL;
            S_MUL:    state_next = S_DIV;
            S_DIV:
            begin
                if (!status.div_busy)
                    state_next = S_STORE;
            end
            S_STORE:
            begin
                if (axis_reg)
                    state_next = S_FINISH;
                else
                begin
                    axis_next  = 1'b1;
                    state_next = S_PHASE;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result until taken, load a new one when finished
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_div_launch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> status.div_busy)
        else $error("divider did not start");

endmodule

>>> src/periodic_decaying_shake_generator.sv
// Top level of the periodic decaying shake generator.
//
//  channel  | direction | transaction carries
//  ---------+-----------+------------------------------------------------
//  item     | in        | action (tick/start/stop), dt_ms
//  result   | out       | offset_horizontal, offset_vertical, in_shake
//  cfg      | in        | index, data (register write, always ready)
//
//  A tick that produces offsets runs the per-axis arithmetic for both axes
//  in turn; start, stop and other ticks go straight to the finish. Each axis
//  waits on the 13-step serial divider shared by both axes.
//  rst_n is asynchronous; it restores the configuration defaults and stops.
//  A finished result waits in the output register; the next transaction is
//  accepted meanwhile and stalls only at its own finish until that is taken.
module periodic_decaying_shake_generator
    import pdsg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int DT_BITS          = 10
)
(
    input  logic          clk,
    input  logic          rst_n,
    pdsg_item_if.sink     item,
    pdsg_result_if.source result,
    pdsg_cfg_if.sink      cfg
);

    dp_cmd_t                 cmd;
    dp_status_t              status;
    logic                    in_ready;
    logic                    out_valid;
    logic signed [OFF_W-1:0] out_h;
    logic signed [OFF_W-1:0] out_v;
    logic                    out_shake;

    pdsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    pdsg_datapath #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .DT_BITS          (DT_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_action (item.action),
        .item_dt     (item.dt_ms),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .cmd         (cmd),
        .status      (status),
        .out_h       (out_h),
        .out_v       (out_v),
        .out_shake   (out_shake)
    );

    // Drive the channels
    assign item.ready               = in_ready;
    assign cfg.ready                = 1'b1;
    assign result.valid             = out_valid;
    assign result.offset_horizontal = out_h;
    assign result.offset_vertical   = out_v;
    assign result.in_shake          = out_shake;

endmodule
